>>> hdl/dfec_pkg.sv
// Package for the date-format element checker.
// Holds widths, status codes, element codes and the conflict group table.
// No dependencies.
package dfec_pkg;

  localparam int unsigned CodeW    = 6;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned MapW     = 60;
  localparam int unsigned GroupW   = 4;
  localparam int unsigned NumGroup = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [MapW-1:0]    map_t;
  typedef logic [GroupW-1:0]  group_t;

  localparam status_t StOk        = 4'd0;
  localparam status_t StBadCode   = 4'd1;
  localparam status_t StBadFormat = 4'd2;
  localparam status_t StDuplicate = 4'd3;
  localparam status_t StGroupBase = 4'd4;

  localparam code_t CodeCount = 6'd60;
  localparam code_t FirstFf   = 6'd11;
  localparam code_t LastFf    = 6'd20;
  localparam code_t CodeTzh   = 6'd54;
  localparam code_t CodeTzm   = 6'd55;
  localparam code_t CodeTzd   = 6'd56;
  localparam code_t CodeTzr   = 6'd57;

  localparam logic [CfgIdxW-1:0] CfgFractionAllowed = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimezoneAllowed = 1'd1;

  localparam group_t NoGroup = 4'd15;

  // group per element code; codes 60..63 padded
  localparam group_t GroupOf [64] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd0, 4'd0, 4'd3, 4'd3, NoGroup, 4'd7,
    4'd3, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup,
    NoGroup, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, NoGroup,
    4'd6, 4'd6, 4'd6, 4'd2, 4'd2, 4'd2, 4'd2, NoGroup, 4'd1, 4'd1,
    NoGroup, NoGroup, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, NoGroup, 4'd7,
    NoGroup, NoGroup, NoGroup, NoGroup
  };

endpackage

>>> hdl/dfec_in_if.sv
// Input channel of the date-format element checker: one element code per item.
// Depends on dfec_pkg.
interface dfec_in_if import dfec_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t element_code;
  logic  is_last;

  modport source (output valid, output element_code, output is_last, input ready);
  modport sink   (input valid, input element_code, input is_last, output ready);
endinterface

>>> hdl/dfec_out_if.sv
// Result channel of the date-format element checker: one result per item.
// Depends on dfec_pkg.
interface dfec_out_if import dfec_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  logic    format_done;
  map_t    seen_map;

  modport source (output valid, output status, output format_done, output seen_map,
                  input ready);
  modport sink   (input valid, input status, input format_done, input seen_map,
                  output ready);
endinterface

>>> hdl/date_format_element_checker_top.sv
// Date-format element checker, top level.
// Result path: an accepted item passes through the input register and then the result register.
// Throughput: 1 item per cycle while result_o.ready holds; the state update is one table lookup and bitmap test.
// Reset (rst_ni, async, active low): empty pipeline, cleared maps and status,
// fraction_allowed = 1, timezone_allowed = 0.
// Depends on dfec_pkg, dfec_in_if, dfec_out_if.
module date_format_element_checker_top import dfec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dfec_in_if.sink             item_i,
  dfec_out_if.source          result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic    frac_ok_q, tz_ok_q;
  logic    in_valid_q;
  code_t   code_q;
  logic    last_q;
  logic    res_valid_q;
  status_t res_status_q;
  logic    res_done_q;
  map_t    res_map_q;
  map_t    seen_q, seen_d;
  logic [NumGroup-1:0] groups_q, groups_d;
  status_t sticky_q, sticky_d;
  status_t status_c;
  map_t    map_c;

  logic s2_ready, s1_ready, s2_load;

  assign s2_ready = !res_valid_q || result_o.ready;
  assign s1_ready = !in_valid_q || s2_ready;
  assign s2_load  = in_valid_q && s2_ready;

  assign item_i.ready         = s1_ready;
  assign result_o.valid       = res_valid_q;
  assign result_o.status      = res_status_q;
  assign result_o.format_done = res_done_q;
  assign result_o.seen_map    = res_map_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_ok_q <= 1'b1;
      tz_ok_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFractionAllowed: frac_ok_q <= cfg_data_i[0];
        CfgTimezoneAllowed: tz_ok_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s1_ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && item_i.valid) begin
      code_q <= item_i.element_code;
      last_q <= item_i.is_last;
    end
  end

  // element check
  always_comb begin
    map_t   code_bit;
    group_t grp;
    logic   is_ff, is_tz;
    code_bit = map_t'(1) << code_q;
    grp      = GroupOf[code_q];
    is_ff    = (code_q >= FirstFf) && (code_q <= LastFf);
    is_tz    = (code_q == CodeTzh) || (code_q == CodeTzm) ||
               (code_q == CodeTzd) || (code_q == CodeTzr);
    status_c = sticky_q;
    map_c    = seen_q;
    groups_d = groups_q;
    if (sticky_q == StOk) begin
      if (code_q >= CodeCount) begin
        status_c = StBadCode;
      end else if ((is_ff && !frac_ok_q) || (is_tz && !tz_ok_q)) begin
        status_c = StBadFormat;
      end else if (|(seen_q & code_bit)) begin
        status_c = StDuplicate;
      end else begin
        map_c = seen_q | code_bit;
        if (grp != NoGroup) begin
          if (groups_q[grp[2:0]]) begin
            status_c = StGroupBase + grp;
          end else begin
            groups_d[grp[2:0]] = 1'b1;
          end
        end
      end
    end
    if (last_q && status_c == StOk && map_c[CodeTzm] && !map_c[CodeTzh]) begin
      status_c = StBadFormat;
    end
    seen_d   = map_c;
    sticky_d = status_c;
    if (last_q) begin
      seen_d   = '0;
      groups_d = '0;
      sticky_d = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      groups_q    <= '0;
      sticky_q    <= StOk;
      res_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        res_valid_q <= in_valid_q;
      end
      if (s2_load) begin
        seen_q   <= seen_d;
        groups_q <= groups_d;
        sticky_q <= sticky_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_status_q <= status_c;
      res_done_q   <= last_q;
      res_map_q    <= map_c;
    end
  end

endmodule

>>> hdl/dfec_checker.sv
// Port-level checks for the date-format element checker, bound to the top level.
// Depends on dfec_pkg and date_format_element_checker_top.
module dfec_checker import dfec_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input status_t status_i,
  input logic    format_done_i,
  input map_t    seen_map_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_dup_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == StDuplicate |-> seen_map_i != '0)
    else $error("duplicate reported with empty seen map");

  a_group_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i >= StGroupBase |-> $countones(seen_map_i) >= 2)
    else $error("group conflict with fewer than two codes");

  a_tzm_tzh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && format_done_i && status_i == StOk |->
      !(seen_map_i[CodeTzm] && !seen_map_i[CodeTzh]))
    else $error("TZM without TZH passed");

endmodule

bind date_format_element_checker_top dfec_checker u_dfec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .status_i      (result_o.status),
  .format_done_i (result_o.format_done),
  .seen_map_i    (result_o.seen_map)
);

>>> verif/tb_date_format_element_checker_top.sv
// Testbench for date_format_element_checker_top: directed and random element streams,
// each result checked against an in-bench model of the seen map, groups and sticky status.
// Depends on dfec_pkg, dfec_in_if, dfec_out_if and the top level.
module tb_date_format_element_checker_top;
  import dfec_pkg::*;

  typedef struct packed {
    status_t status;
    logic    format_done;
    map_t    seen_map;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dfec_in_if  item_ch ();
  dfec_out_if result_ch ();

  date_format_element_checker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // format state mirror
  map_t       seen_codes;
  logic [7:0] used_groups;
  status_t    held_status;
  logic       fraction_ok;
  logic       timezone_ok;

  result_t expected_results [$];
  int      fail_count;
  int      items_sent;
  bit      calm;
  int      holdoff_len;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int conflict_group(code_t code);
    case (code) inside
      [0:3]:                         return 4;
      4, 5, [24:28], 42, 43, 45, 46: return 0;
      6, 7, 10:                      return 3;
      9, 59:                         return 7;
      [21:23]:                       return 5;
      [30:32]:                       return 6;
      [33:36]:                       return 2;
      38, 39, 44, [47:51]:           return 1;
      default:                       return -1;
    endcase
  endfunction

  function automatic bit code_allowed(code_t code);
    if (code >= CodeCount) return 1'b0;
    if (code >= FirstFf && code <= LastFf && !fraction_ok) return 1'b0;
    if (code >= CodeTzh && code <= CodeTzr && !timezone_ok) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit idle_draw();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  task automatic predict_element(input code_t code, input logic last);
    int grp;
    result_t res;
    if (held_status == StOk) begin
      if (code >= CodeCount) begin
        held_status = StBadCode;
      end else if (code >= FirstFf && code <= LastFf && !fraction_ok) begin
        held_status = StBadFormat;
      end else if (code >= CodeTzh && code <= CodeTzr && !timezone_ok) begin
        held_status = StBadFormat;
      end else if (seen_codes[code]) begin
        held_status = StDuplicate;
      end else begin
        seen_codes[code] = 1'b1;
        grp = conflict_group(code);
        if (grp >= 0) begin
          if (used_groups[grp]) held_status = StGroupBase + status_t'(grp);
          else used_groups[grp] = 1'b1;
        end
      end
    end
    if (last && held_status == StOk && seen_codes[CodeTzm] && !seen_codes[CodeTzh])
      held_status = StBadFormat;
    res.status      = held_status;
    res.format_done = last;
    res.seen_map    = seen_codes;
    expected_results = {expected_results, res};
    if (last) begin
      seen_codes  = '0;
      used_groups = '0;
      held_status = StOk;
    end
  endtask

  task automatic send_element(input code_t code, input logic last);
    while (idle_draw()) begin
      @(negedge clk_i);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_ch.valid        <= 1'b1;
    item_ch.element_code <= code;
    item_ch.is_last      <= last;
    do @(posedge clk_i); while (!item_ch.ready);
    predict_element(code, last);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFractionAllowed) fraction_ok = data[0];
    else if (idx == CfgTimezoneAllowed) timezone_ok = data[0];
  endtask

  // mostly clean formats; some codes drawn from the full 6-bit range
  task automatic send_random_format();
    map_t       taken;
    logic [7:0] groups;
    int         len;
    int         c;
    int         g;
    int         k;
    taken  = '0;
    groups = '0;
    len    = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      c = -1;
      if ($urandom_range(99) < 75) begin
        for (k = 0; k < 40 && c < 0; k++) begin
          c = $urandom_range(59);
          g = conflict_group(code_t'(c));
          if (taken[c] || !code_allowed(code_t'(c)) || (g >= 0 && groups[g])) c = -1;
        end
      end
      if (c < 0) c = $urandom_range(63);
      if (c < 60) begin
        taken[c] = 1'b1;
        g = conflict_group(code_t'(c));
        if (g >= 0) groups[g] = 1'b1;
      end
      send_element(code_t'(c), i == len - 1);
    end
  endtask

  task automatic test_element_checks();
    send_element(6'd0, 1'b1);
    send_element(6'd63, 1'b1);
    send_element(6'd60, 1'b0);
    send_element(6'd5, 1'b1);
    send_element(FirstFf, 1'b0);
    send_element(LastFf, 1'b1);
    send_element(CodeTzh, 1'b1);
    send_element(6'd7, 1'b0);
    send_element(6'd7, 1'b1);
    send_element(6'd0, 1'b0);
    send_element(6'd1, 1'b0);
    send_element(6'd2, 1'b1);
    send_element(6'd8, 1'b0);
    send_element(6'd29, 1'b1);
    wait_drained();
  endtask

  task automatic test_restricted_elements();
    write_reg(CfgFractionAllowed, 1'b0);
    write_reg(CfgTimezoneAllowed, 1'b1);
    send_element(6'd12, 1'b1);
    send_element(CodeTzm, 1'b1);
    send_element(CodeTzh, 1'b0);
    send_element(CodeTzm, 1'b1);
    send_element(6'd59, 1'b0);
    send_element(6'd9, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_formats();
    logic [1:0] setting [4] = '{2'b10, 2'b01, 2'b11, 2'b00};
    int stop_at;
    foreach (setting[i]) begin
      write_reg(CfgFractionAllowed, setting[i][1]);
      write_reg(CfgTimezoneAllowed, setting[i][0]);
      stop_at = items_sent + 300;
      while (items_sent < stop_at) send_random_format();
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    int stop_at;
    write_reg(CfgTimezoneAllowed, 1'b1);
    calm        = 1'b1;
    holdoff_len = 200;
    stop_at     = items_sent + 40;
    while (items_sent < stop_at) send_random_format();
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_full_rate();
    int stop_at;
    calm    = 1'b1;
    stop_at = items_sent + 150;
    while (items_sent < stop_at) send_random_format();
    calm = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (holdoff_len > 0) begin
      result_ch.ready <= 1'b0;
      holdoff_len     <= holdoff_len - 1;
    end else begin
      result_ch.ready <= !idle_draw();
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none pending: status %0d", result_ch.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_ch.status);
          fail_count++;
        end
        if (result_ch.format_done !== want.format_done) begin
          $error("format_done: expected %0b, got %0b", want.format_done,
                 result_ch.format_done);
          fail_count++;
        end
        if (result_ch.seen_map !== want.seen_map) begin
          $error("seen_map: expected %h, got %h", want.seen_map, result_ch.seen_map);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    item_ch.valid        = 1'b0;
    item_ch.element_code = '0;
    item_ch.is_last      = 1'b0;
    result_ch.ready      = 1'b0;
    seen_codes           = '0;
    used_groups          = '0;
    held_status          = StOk;
    fraction_ok          = 1'b1;
    timezone_ok          = 1'b0;
    fail_count           = 0;
    items_sent           = 0;
    calm                 = 1'b0;
    holdoff_len          = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_element_checks();
    test_restricted_elements();
    test_random_formats();
    test_output_backpressure();
    test_full_rate();

    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dfec_pkg.sv
hdl/dfec_in_if.sv
hdl/dfec_out_if.sv
hdl/date_format_element_checker_top.sv
hdl/dfec_checker.sv
verif/tb_date_format_element_checker_top.sv
